// ===== sv/psfm_pkg.sv =====
// ----------------------------------------------------------------------------
// psfm_pkg
// Shared types and constants of the pooled slot FIFO manager.
// ----------------------------------------------------------------------------
package psfm_pkg;

  localparam int SlotW        = 4;
  localparam int CountW       = 5;
  localparam int DefaultSlots = 16;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_DEQUEUE = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_INIT = 4'b0001,
    S_IDLE = 4'b0010,
    S_EXEC = 4'b0100,
    S_LINK = 4'b1000
  } state_t;

endpackage

// ===== sv/psfm_if.sv =====
// ----------------------------------------------------------------------------
// psfm_if
// Command and response channels of the pooled slot FIFO manager.
// ----------------------------------------------------------------------------
interface psfm_in_if;
  logic                        valid;
  logic                        ready;
  psfm_pkg::op_t               op;
  logic [psfm_pkg::SlotW-1:0]  slot;

  modport source (output valid, output op, output slot, input ready);
  modport sink   (input valid, input op, input slot, output ready);
endinterface

interface psfm_out_if;
  logic                        valid;
  logic                        ready;
  logic [psfm_pkg::SlotW-1:0]  result_slot;
  logic                        found;
  logic [psfm_pkg::CountW-1:0] queued_count;

  modport source (output valid, output result_slot, output found, output queued_count,
                  input ready);
  modport sink   (input valid, input result_slot, input found, input queued_count,
                  output ready);
endinterface

// ===== sv/psfm_ram.sv =====
// ----------------------------------------------------------------------------
// psfm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psfm_ram #(
  parameter int Width = 5,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pooled_slot_fifo_manager.sv =====
// ----------------------------------------------------------------------------
// pooled_slot_fifo_manager
// Slot pool with a free list (LIFO) and one linked FIFO queue sharing a
// single link memory.
//
//   channel  dir  payload                            handshake
//   req      in   op, slot                           valid / ready
//   rsp      out  result_slot, found, queued_count   valid / ready
//
// Each item is accepted in S_IDLE, which reads the link memory; S_EXEC
// then consumes the read data and writes back. Enqueue onto a non-empty
// queue adds S_LINK, which writes the old tail's link.
// After reset S_INIT sweeps all SLOTS entries of the link memory; req.ready
// stays low until it ends. A result waiting on rsp does not block the
// next accept; only its write-back waits until the response register frees.
// ----------------------------------------------------------------------------
module pooled_slot_fifo_manager #(
  parameter int SLOTS = psfm_pkg::DefaultSlots
) (
  input logic        clk,
  input logic        rst,
  psfm_in_if.sink    req,
  psfm_out_if.source rsp
);

  import psfm_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int XW = (PW > SlotW) ? PW : SlotW;
  localparam logic [PW-1:0] Nil = PW'(SLOTS);

  state_t            state, state_next;
  logic [AW-1:0]     init_idx, init_idx_next;
  logic [PW-1:0]     pool_head, pool_head_next;
  logic [PW-1:0]     queue_head, queue_head_next;
  logic [PW-1:0]     queue_tail, queue_tail_next;
  logic [PW-1:0]     queue_size, queue_size_next;
  op_t               cmd_op;
  logic [SlotW-1:0]  cmd_slot;
  logic              rsp_valid;
  logic [SlotW-1:0]  rsp_slot;
  logic              rsp_found;
  logic [CountW-1:0] rsp_count;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [PW-1:0]     mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [PW-1:0]     mem_rdata;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic [PW-1:0]     out_slot;
  logic              out_found;
  logic              slot_ok;
  logic [PW-1:0]     cmd_ptr;

  psfm_ram #(
    .Width (PW),
    .Depth (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req.ready        = (state == S_IDLE);
  assign accept           = req.valid && (state == S_IDLE);
  assign out_free         = !rsp_valid || rsp.ready;
  assign slot_ok          = XW'(cmd_slot) < XW'(SLOTS);
  assign cmd_ptr          = PW'(cmd_slot);
  assign mem_re           = accept;
  assign mem_raddr        = (req.op == OP_ALLOC) ? AW'(pool_head) : AW'(queue_head);

  assign rsp.valid        = rsp_valid;
  assign rsp.result_slot  = rsp_slot;
  assign rsp.found        = rsp_found;
  assign rsp.queued_count = rsp_count;

  always_comb begin
    state_next      = state;
    init_idx_next   = init_idx;
    pool_head_next  = pool_head;
    queue_head_next = queue_head;
    queue_tail_next = queue_tail;
    queue_size_next = queue_size;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = Nil;
    out_load        = 1'b0;
    out_slot        = '0;
    out_found       = 1'b0;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_idx;
        mem_wdata = PW'(init_idx) + PW'(1);
        if (init_idx == AW'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end else begin
          init_idx_next = init_idx + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          unique case (cmd_op)
            OP_ALLOC: begin
              if (pool_head < Nil) begin
                out_slot       = pool_head;
                out_found      = 1'b1;
                pool_head_next = mem_rdata;
                mem_we         = 1'b1;
                mem_waddr      = AW'(pool_head);
              end
            end
            OP_ENQUEUE: begin
              if (slot_ok) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cmd_slot);
                if (queue_size < Nil) begin
                  queue_size_next = queue_size + PW'(1);
                end
                if (queue_head >= Nil || queue_tail >= Nil) begin
                  queue_head_next = cmd_ptr;
                  queue_tail_next = cmd_ptr;
                end else begin
                  out_load   = 1'b0;
                  state_next = S_LINK;
                end
              end
            end
            OP_DEQUEUE: begin
              if (queue_head < Nil) begin
                out_slot  = queue_head;
                out_found = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = AW'(queue_head);
                if (mem_rdata >= Nil) begin
                  queue_head_next = Nil;
                  queue_tail_next = Nil;
                end else begin
                  queue_head_next = mem_rdata;
                end
                if (queue_size != '0) begin
                  queue_size_next = queue_size - PW'(1);
                end
              end
            end
            OP_RELEASE: begin
              if (slot_ok) begin
                mem_we         = 1'b1;
                mem_waddr      = AW'(cmd_slot);
                mem_wdata      = pool_head;
                pool_head_next = cmd_ptr;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_LINK: begin
        mem_we          = 1'b1;
        mem_waddr       = AW'(queue_tail);
        mem_wdata       = cmd_ptr;
        queue_tail_next = cmd_ptr;
        out_load        = 1'b1;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_idx   <= '0;
      pool_head  <= '0;
      queue_head <= Nil;
      queue_tail <= Nil;
      queue_size <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      init_idx   <= init_idx_next;
      pool_head  <= pool_head_next;
      queue_head <= queue_head_next;
      queue_tail <= queue_tail_next;
      queue_size <= queue_size_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op   <= req.op;
      cmd_slot <= req.slot;
    end
    if (out_load) begin
      rsp_slot  <= SlotW'(out_slot);
      rsp_found <= out_found;
      rsp_count <= CountW'(queue_size_next);
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pooled slot FIFO manager. A short scripted run
// covers empty queue, misuse and slot extremes. Random traffic then keeps
// mostly well-formed alloc/enqueue/dequeue/release sequences with some noise,
// under three idling patterns. Replies are checked against scripted values
// where given, else an in-bench model of the free list, queue and link memory.
// ----------------------------------------------------------------------------
module tb_top;
  import psfm_pkg::*;

  localparam int          SLOT_COUNT = DefaultSlots;
  localparam logic [4:0]  NIL        = 5'(SLOT_COUNT);
  localparam int          RAND_ITEMS = 576;
  localparam int          CYCLE_CAP  = 300000;
  localparam int          SCRIPT_LEN = 24;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic              found;
    logic [CountW-1:0] count;
  } reply_t;

  typedef struct packed {
    op_t              op;
    logic [SlotW-1:0] slot;
    logic             chk;
    reply_t           exp;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{OP_DEQUEUE, 4'd0,  1'b1, '{4'd0,  1'b0, 5'd0}},
    '{OP_ALLOC,   4'd0,  1'b1, '{4'd0,  1'b1, 5'd0}},
    '{OP_ENQUEUE, 4'd0,  1'b1, '{4'd0,  1'b0, 5'd1}},
    '{OP_ALLOC,   4'd15, 1'b1, '{4'd1,  1'b1, 5'd1}},
    '{OP_ENQUEUE, 4'd1,  1'b1, '{4'd0,  1'b0, 5'd2}},
    '{OP_DEQUEUE, 4'd0,  1'b1, '{4'd0,  1'b1, 5'd1}},
    '{OP_RELEASE, 4'd0,  1'b1, '{4'd0,  1'b0, 5'd1}},
    '{OP_DEQUEUE, 4'd0,  1'b1, '{4'd1,  1'b1, 5'd0}},
    '{OP_DEQUEUE, 4'd0,  1'b1, '{4'd0,  1'b0, 5'd0}},
    '{OP_RELEASE, 4'd1,  1'b1, '{4'd0,  1'b0, 5'd0}},
    '{OP_ALLOC,   4'd0,  1'b1, '{4'd1,  1'b1, 5'd0}},
    '{OP_ALLOC,   4'd0,  1'b1, '{4'd0,  1'b1, 5'd0}},
    '{OP_ALLOC,   4'd0,  1'b1, '{4'd2,  1'b1, 5'd0}},
    '{OP_RELEASE, 4'd15, 1'b1, '{4'd0,  1'b0, 5'd0}},
    '{OP_ALLOC,   4'd0,  1'b1, '{4'd15, 1'b1, 5'd0}},
    '{OP_ENQUEUE, 4'd15, 1'b1, '{4'd0,  1'b0, 5'd1}},
    '{OP_ENQUEUE, 4'd15, 1'b1, '{4'd0,  1'b0, 5'd2}},
    '{OP_DEQUEUE, 4'd0,  1'b1, '{4'd15, 1'b1, 5'd1}},
    '{OP_DEQUEUE, 4'd0,  1'b1, '{4'd15, 1'b1, 5'd0}},
    '{OP_DEQUEUE, 4'd0,  1'b1, '{4'd0,  1'b0, 5'd0}},
    '{OP_ENQUEUE, 4'd2,  1'b1, '{4'd0,  1'b0, 5'd1}},
    '{OP_RELEASE, 4'd2,  1'b0, '0},
    '{OP_DEQUEUE, 4'd0,  1'b0, '0},
    '{OP_RELEASE, 4'd15, 1'b0, '0}
  };

  logic clk;
  logic rst;

  psfm_in_if  req_ch ();
  psfm_out_if rsp_ch ();

  pooled_slot_fifo_manager #(.SLOTS(SLOT_COUNT)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // model state
  logic [4:0] links [SLOT_COUNT];
  logic [4:0] pool_top;
  logic [4:0] q_head;
  logic [4:0] q_tail;
  logic [4:0] q_size;

  reply_t slot_replies [$];

  int send_idle;
  int recv_idle;
  int mismatches;
  int cycles;
  int op_tally [4];
  int pool_dry;
  int queue_dry;
  int queue_full;
  int replies_seen;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      replies_seen++;
      if (slot_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply slot=%0d found=%0d count=%0d", $time,
                 rsp_ch.result_slot, rsp_ch.found, rsp_ch.queued_count);
      end else begin
        want = slot_replies.pop_front();
        if (rsp_ch.result_slot !== want.slot) begin
          mismatches++;
          $display("%0t: result_slot expected %0d actual %0d", $time, want.slot,
                   rsp_ch.result_slot);
        end
        if (rsp_ch.found !== want.found) begin
          mismatches++;
          $display("%0t: found expected %0d actual %0d", $time, want.found,
                   rsp_ch.found);
        end
        if (rsp_ch.queued_count !== want.count) begin
          mismatches++;
          $display("%0t: queued_count expected %0d actual %0d", $time, want.count,
                   rsp_ch.queued_count);
        end
      end
    end
  end

  task automatic run_slot_op(input op_t op, input logic [3:0] s, output reply_t r);
    r = '0;
    case (op)
      OP_ALLOC: begin
        if (pool_top < NIL) begin
          r.slot   = pool_top[3:0];
          r.found  = 1'b1;
          pool_top = links[r.slot];
          links[r.slot] = NIL;
        end
      end
      OP_ENQUEUE: begin
        links[s] = NIL;
        if (q_size < NIL) q_size = q_size + 5'd1;
        if (q_head >= NIL || q_tail >= NIL) begin
          q_head = {1'b0, s};
          q_tail = {1'b0, s};
        end else begin
          links[q_tail[3:0]] = {1'b0, s};
          q_tail = {1'b0, s};
        end
      end
      OP_DEQUEUE: begin
        if (q_head < NIL) begin
          r.slot  = q_head[3:0];
          r.found = 1'b1;
          q_head  = links[r.slot];
          links[r.slot] = NIL;
          if (q_head >= NIL) begin
            q_head = NIL;
            q_tail = NIL;
          end
          if (q_size > 0) q_size = q_size - 5'd1;
        end
      end
      default: begin
        links[s] = pool_top;
        pool_top = {1'b0, s};
      end
    endcase
    r.count = q_size;
  endtask

  // slots on neither the free list nor the queue
  function automatic logic [15:0] loose_slots();
    logic [15:0] held;
    logic [4:0]  p;
    int          k;
    held = '0;
    p = pool_top;
    for (k = 0; k < SLOT_COUNT && p < NIL; k++) begin
      held[p[3:0]] = 1'b1;
      p = links[p[3:0]];
    end
    p = q_head;
    for (k = 0; k < SLOT_COUNT && p < NIL; k++) begin
      held[p[3:0]] = 1'b1;
      p = links[p[3:0]];
    end
    return ~held;
  endfunction

  function automatic void pick_item(input int mode, output op_t op, output logic [3:0] s);
    logic [15:0] loose;
    int          n;
    int          pick;
    int          roll;
    int          lo_a;
    int          lo_e;
    int          lo_d;
    loose = loose_slots();
    n = $countones(loose);
    s = 4'($urandom_range(15));
    if (mode == 3 || $urandom_range(9) == 0) begin
      op = op_t'($urandom_range(3));
      if (mode == 3 && $urandom_range(1) == 1) op = OP_ENQUEUE;
      return;
    end
    case (mode)
      1:       begin lo_a = 45; lo_e = 90; lo_d = 95; end
      2:       begin lo_a = 5;  lo_e = 10; lo_d = 55; end
      default: begin lo_a = 25; lo_e = 50; lo_d = 75; end
    endcase
    roll = $urandom_range(99);
    if (roll < lo_a)      op = OP_ALLOC;
    else if (roll < lo_e) op = OP_ENQUEUE;
    else if (roll < lo_d) op = OP_DEQUEUE;
    else                  op = OP_RELEASE;
    if ((op == OP_ENQUEUE || op == OP_RELEASE) && n == 0)
      op = (mode == 2) ? OP_DEQUEUE : OP_ALLOC;
    if ((op == OP_ENQUEUE || op == OP_RELEASE) && n > 0) begin
      pick = $urandom_range(n - 1);
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (loose[i]) begin
          if (pick == 0) s = 4'(i);
          pick--;
        end
      end
    end
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input op_t op, input logic [3:0] s, input logic chk,
                           input reply_t typed);
    reply_t r;
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.slot  <= s;
    do @(posedge clk); while (!req_ch.ready);
    run_slot_op(op, s, r);
    op_tally[op]++;
    if (op == OP_ALLOC && !r.found) pool_dry++;
    if (op == OP_DEQUEUE && !r.found) queue_dry++;
    if (r.count == NIL) queue_full++;
    slot_replies.push_back(chk ? typed : r);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (slot_replies.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int s_idle, input int r_idle);
    op_t        op;
    logic [3:0] s;
    int         mode;
    send_idle = s_idle;
    recv_idle = r_idle;
    mode = 0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) mode = $urandom_range(3);
      pick_item(mode, op, s);
      send_item(op, s, 1'b0, '0);
    end
    hold_until_drained();
  endtask

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_ALLOC;
    req_ch.slot  = '0;
    rsp_ch.ready = 1'b0;
    cycles       = 0;
    mismatches   = 0;
    pool_dry     = 0;
    queue_dry    = 0;
    queue_full   = 0;
    replies_seen = 0;
    send_idle    = 12;
    recv_idle    = 86;
    op_tally     = '{0, 0, 0, 0};
    for (int i = 0; i < SLOT_COUNT; i++) links[i] = 5'(i + 1);
    pool_top = '0;
    q_head   = NIL;
    q_tail   = NIL;
    q_size   = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++)
      send_item(SCRIPT[i].op, SCRIPT[i].slot, SCRIPT[i].chk, SCRIPT[i].exp);
    hold_until_drained();

    random_phase(12, 86);
    random_phase(86, 12);
    random_phase(0, 0);

    while (slot_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d items: %0d alloc, %0d enqueue, %0d dequeue, %0d release; %0d replies",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3], op_tally[0],
             op_tally[1], op_tally[2], op_tally[3], replies_seen);
    $display("Pool ran dry %0d times, queue empty on dequeue %0d, queue at full count %0d",
             pool_dry, queue_dry, queue_full);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
